FILE: design/calo_tower_et_ratio_encode_defines.svh
// Assertion macros for the calorimeter tower encoder.
// Included by the top level; expects clk_i and rst_ni in the including scope.
`ifndef CALO_TOWER_ET_RATIO_ENCODE_DEFINES_SVH
`define CALO_TOWER_ET_RATIO_ENCODE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTERE_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("ctere assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTERE_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("ctere assertion failed");

`endif

FILE: design/ctere_pkg.sv
// Shared types, codes and helpers of the calorimeter tower encoder.
// No dependencies; used by the top level, the result logic and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ctere_pkg;

  localparam int unsigned ET_BITS_DEF     = 8;
  localparam int unsigned ETA_ROWS_DEF    = 32;
  localparam int unsigned HF_ETA_ROWS_DEF = 16;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned ETA_IN_W  = 5;
  localparam int unsigned IN_ET_W   = 8;
  localparam int unsigned FB_W      = 6;
  localparam int unsigned ABS_ETA_W = 6;
  localparam int unsigned LUT_W     = 15;
  localparam int unsigned HF_W      = 8;
  localparam int unsigned LOG_W     = 3;
  localparam int unsigned LOG_LSB   = 12;
  localparam int unsigned SUM_W     = 9;
  localparam int unsigned ET_EXT_W  = 13;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_TOWER   = 3'd0,
    OP_HF      = 3'd1,
    OP_WR_ECAL = 3'd2,
    OP_WR_HCAL = 3'd3,
    OP_WR_HF   = 3'd4
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_USE_ECAL_LUT = 3'd0,
    REG_USE_HCAL_LUT = 3'd1,
    REG_USE_HF_LUT   = 3'd2,
    REG_ET_SUM_LIMIT = 3'd3,
    REG_ER_LIMIT     = 3'd4
  } reg_e;

  typedef struct packed {
    logic             use_ecal_lut;
    logic             use_hcal_lut;
    logic             use_hf_lut;
    logic [SUM_W-1:0] et_sum_limit;
    logic [LOG_W-1:0] er_limit;
  } cfg_t;

  // One item on its way from the input register to the result logic.
  typedef struct packed {
    logic                 is_hf;
    logic [IN_ET_W-1:0]   ecal_et;
    logic                 ecal_fg;
    logic [IN_ET_W-1:0]   hcal_et;
    logic [FB_W-1:0]      hcal_fb;
    logic [ABS_ETA_W-1:0] abs_eta;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   tower_et;
    logic [LOG_W-1:0]   er_code;
    logic               zero_flag;
    logic               eohr_flag;
    logic               hcal_flag;
    logic               ecal_flag;
    logic [IN_ET_W-1:0] ecal_calibrated;
    logic [IN_ET_W-1:0] hcal_calibrated;
  } res_t;

  // Position of the highest set bit; zero for an input of zero.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [IN_ET_W-1:0] v);
    logic [LOG_W-1:0] n;
    n = '0;
    for (int i = 1; i < IN_ET_W; i++) begin
      if (v[i]) begin
        n = LOG_W'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: design/ctere_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies; holds the calibration tables of the tower encoder.
`timescale 1ns / 1ps
`default_nettype none

module ctere_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/ctere_encode.sv
// Result logic of the tower encoder: calibration select, saturated sum,
// log-ratio code, flags and forward-tower scaling. Depends on ctere_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctere_encode #(
  parameter int unsigned ET_BITS = ctere_pkg::ET_BITS_DEF
) (
  input  wire ctere_pkg::item_t            item_i,
  input  wire ctere_pkg::cfg_t             cfg_i,
  input  wire logic [ctere_pkg::LUT_W-1:0] ecal_word_i,
  input  wire logic [ctere_pkg::LUT_W-1:0] hcal_word_i,
  input  wire logic [ctere_pkg::HF_W-1:0]  hf_word_i,
  output ctere_pkg::res_t                  res_o
);

  import ctere_pkg::*;

  localparam int unsigned CW = (ET_BITS > IN_ET_W) ? ET_BITS : IN_ET_W;
  localparam int unsigned SW = CW + 1;

  logic [CW-1:0]    cal_e, cal_h;
  logic [LOG_W-1:0] log_e, log_h, flog_e, flog_h;
  logic [SW-1:0]    sum, sum_lim, sum_sat;
  logic [LOG_W-1:0] er;
  logic             zero, eohr;
  logic [HF_W-1:0]  hf_cal, hf_div;
  res_t             tower_res, hf_res;

  always_comb begin
    flog_e = floor_log2(item_i.ecal_et);
    flog_h = floor_log2(item_i.hcal_et);
    if (flog_e > cfg_i.er_limit) begin
      flog_e = cfg_i.er_limit;
    end
    if (flog_h > cfg_i.er_limit) begin
      flog_h = cfg_i.er_limit;
    end

    // A table log code is taken as is, without the cap.
    if (cfg_i.use_ecal_lut) begin
      cal_e = CW'(ecal_word_i[ET_BITS-1:0]);
      log_e = ecal_word_i[LOG_LSB +: LOG_W];
    end else begin
      cal_e = CW'(item_i.ecal_et);
      log_e = flog_e;
    end
    if (cfg_i.use_hcal_lut) begin
      cal_h = CW'(hcal_word_i[ET_BITS-1:0]);
      log_h = hcal_word_i[LOG_LSB +: LOG_W];
    end else begin
      cal_h = CW'(item_i.hcal_et);
      log_h = flog_h;
    end
  end

  always_comb begin
    sum     = SW'(cal_e) + SW'(cal_h);
    sum_lim = SW'(cfg_i.et_sum_limit);
    sum_sat = (sum > sum_lim) ? sum_lim : sum;

    er   = '0;
    zero = 1'b0;
    eohr = 1'b0;
    // A smaller log code on the larger energy saturates the ratio code.
    if (cal_e == '0 || cal_h == '0) begin
      zero = 1'b1;
      eohr = (cal_h == '0) && (cal_e != '0);
    end else if (cal_e == cal_h) begin
      eohr = 1'b1;
    end else if (cal_e > cal_h) begin
      er   = (log_e >= log_h) ? log_e - log_h : cfg_i.er_limit;
      eohr = 1'b1;
    end else begin
      er = (log_h >= log_e) ? log_h - log_e : cfg_i.er_limit;
    end
    if (er > cfg_i.er_limit) begin
      er = cfg_i.er_limit;
    end

    tower_res.tower_et        = sum_sat[SUM_W-1:0];
    tower_res.er_code         = er;
    tower_res.zero_flag       = zero;
    tower_res.eohr_flag       = eohr;
    tower_res.hcal_flag       = item_i.hcal_fb[0];
    tower_res.ecal_flag       = item_i.ecal_fg;
    tower_res.ecal_calibrated = cal_e[IN_ET_W-1:0];
    tower_res.hcal_calibrated = cal_h[IN_ET_W-1:0];
  end

  always_comb begin
    hf_cal = cfg_i.use_hf_lut ? hf_word_i : item_i.hcal_et;
    if (item_i.abs_eta inside {[6'd30:6'd39]}) begin
      hf_div = hf_cal >> 1;
    end else if (item_i.abs_eta inside {6'd40, 6'd41}) begin
      hf_div = hf_cal >> 2;
    end else begin
      hf_div = hf_cal;
    end

    hf_res                 = '0;
    hf_res.tower_et        = SUM_W'(hf_div);
    hf_res.zero_flag       = 1'b1;
    hf_res.hcal_flag       = item_i.hcal_fb[1];
    hf_res.ecal_flag       = item_i.hcal_fb[0];
  end

  assign res_o = item_i.is_hf ? hf_res : tower_res;

endmodule

`default_nettype wire

FILE: design/calo_tower_et_ratio_encode.sv
// Top level of the calorimeter tower energy encoder with ratio code.
// Depends on ctere_pkg, ctere_ram, ctere_encode and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "calo_tower_et_ratio_encode_defines.svh"

// The block takes one item in every clock cycle: busy_o is always low.
// A tower or forward item gives its result on the result ports with done_o
// high, after the registered read of the calibration tables and then the
// result register. The receiver cannot stall the block, so a result must be
// taken in the cycle it is shown. Table-write items give no result and take
// effect for any item taken in a later cycle. Tables hold no reset value and
// need no clearing pass; calibration is valid only for words already loaded.
// The user must write configuration through cfg_we_i only while no item is
// in flight; the block itself does not enforce this.
module calo_tower_et_ratio_encode #(
  parameter int unsigned ET_BITS     = ctere_pkg::ET_BITS_DEF,
  parameter int unsigned ETA_ROWS    = ctere_pkg::ETA_ROWS_DEF,
  parameter int unsigned HF_ETA_ROWS = ctere_pkg::HF_ETA_ROWS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [ctere_pkg::OP_W-1:0]      op_i,
  input  wire logic [ctere_pkg::ETA_IN_W-1:0]  eta_address_i,
  input  wire logic [ctere_pkg::IN_ET_W-1:0]   ecal_et_i,
  input  wire logic                           ecal_fg_i,
  input  wire logic [ctere_pkg::IN_ET_W-1:0]   hcal_et_i,
  input  wire logic [ctere_pkg::FB_W-1:0]      hcal_fb_i,
  input  wire logic [ctere_pkg::ABS_ETA_W-1:0] abs_calo_eta_i,
  input  wire logic                           lut_fb_i,
  input  wire logic [ctere_pkg::IN_ET_W-1:0]   lut_et_i,
  input  wire logic [ctere_pkg::LUT_W-1:0]     lut_value_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [ctere_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ctere_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                                done_o,
  output logic      [ctere_pkg::SUM_W-1:0]     tower_et_o,
  output logic      [ctere_pkg::LOG_W-1:0]     er_code_o,
  output logic                                zero_flag_o,
  output logic                                eohr_flag_o,
  output logic                                hcal_flag_o,
  output logic                                ecal_flag_o,
  output logic      [ctere_pkg::IN_ET_W-1:0]   ecal_calibrated_o,
  output logic      [ctere_pkg::IN_ET_W-1:0]   hcal_calibrated_o
);

  import ctere_pkg::*;

  localparam int unsigned EtaCodes = 2 ** ETA_IN_W;
  localparam int unsigned RowW     = $clog2(ETA_ROWS);
  localparam int unsigned HfRowW   = $clog2(HF_ETA_ROWS);
  localparam int unsigned EhDepth  = ETA_ROWS * 2 * (2 ** ET_BITS);
  localparam int unsigned HfDepth  = HF_ETA_ROWS * (2 ** ET_BITS);
  localparam int unsigned EhAw     = $clog2(EhDepth);
  localparam int unsigned HfAw     = $clog2(HfDepth);
  localparam logic [ET_EXT_W-1:0] EtMax = ET_EXT_W'((2 ** ET_BITS) - 1);

  // Eta row of each eta code, reduced modulo the table's row count.
  logic [RowW-1:0]   eh_row_tab [EtaCodes];
  logic [HfRowW-1:0] hf_row_tab [EtaCodes];

  for (genvar g = 0; g < EtaCodes; g++) begin : g_row_tab
    assign eh_row_tab[g] = RowW'(g % ETA_ROWS);
    assign hf_row_tab[g] = HfRowW'(g % HF_ETA_ROWS);
  end

  cfg_t  cfg_q;
  item_t s1_item_q, item_d;
  logic  s1_valid_q, s1_valid_d;
  res_t  res_q, res_d;
  logic  done_q;

  logic [IN_ET_W-1:0] ecal_raw, hcal_raw;
  logic [RowW-1:0]    eh_row;
  logic [HfRowW-1:0]  hf_row;
  logic               lut_et_ok;
  logic               is_tower, is_hf, wr_ecal, wr_hcal, wr_hf;

  logic [EhAw-1:0]  ecal_raddr, hcal_raddr, eh_waddr;
  logic [HfAw-1:0]  hf_raddr, hf_waddr;
  logic [LUT_W-1:0] ecal_word, hcal_word;
  logic [HF_W-1:0]  hf_word;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_ecal_lut <= 1'b0;
      cfg_q.use_hcal_lut <= 1'b0;
      cfg_q.use_hf_lut   <= 1'b0;
      cfg_q.et_sum_limit <= '1;
      cfg_q.er_limit     <= '1;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_addr_i))
        REG_USE_ECAL_LUT: cfg_q.use_ecal_lut <= cfg_wdata_i[0];
        REG_USE_HCAL_LUT: cfg_q.use_hcal_lut <= cfg_wdata_i[0];
        REG_USE_HF_LUT:   cfg_q.use_hf_lut   <= cfg_wdata_i[0];
        REG_ET_SUM_LIMIT: cfg_q.et_sum_limit <= cfg_wdata_i[SUM_W-1:0];
        REG_ER_LIMIT:     cfg_q.er_limit     <= cfg_wdata_i[LOG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    is_tower = 1'b0;
    is_hf    = 1'b0;
    wr_ecal  = 1'b0;
    wr_hcal  = 1'b0;
    wr_hf    = 1'b0;
    case (op_e'(op_i))
      OP_TOWER:   is_tower = start_i;
      OP_HF:      is_hf    = start_i;
      OP_WR_ECAL: wr_ecal  = start_i;
      OP_WR_HCAL: wr_hcal  = start_i;
      OP_WR_HF:   wr_hf    = start_i;
      default: begin
      end
    endcase
  end

  always_comb begin
    ecal_raw = ({{(ET_EXT_W - IN_ET_W){1'b0}}, ecal_et_i} > EtMax) ?
               EtMax[IN_ET_W-1:0] : ecal_et_i;
    hcal_raw = ({{(ET_EXT_W - IN_ET_W){1'b0}}, hcal_et_i} > EtMax) ?
               EtMax[IN_ET_W-1:0] : hcal_et_i;
    lut_et_ok = ({{(ET_EXT_W - IN_ET_W){1'b0}}, lut_et_i} <= EtMax);

    eh_row = eh_row_tab[eta_address_i];
    hf_row = hf_row_tab[eta_address_i];

    ecal_raddr = {eh_row, ecal_fg_i, ET_BITS'(ecal_raw)};
    hcal_raddr = {eh_row, hcal_fb_i[0], ET_BITS'(hcal_raw)};
    hf_raddr   = {hf_row, ET_BITS'(hcal_raw)};
    eh_waddr   = {eh_row, lut_fb_i, ET_BITS'(lut_et_i)};
    hf_waddr   = {hf_row, ET_BITS'(lut_et_i)};

    item_d.is_hf   = is_hf;
    item_d.ecal_et = ecal_raw;
    item_d.ecal_fg = ecal_fg_i;
    item_d.hcal_et = hcal_raw;
    item_d.hcal_fb = hcal_fb_i;
    item_d.abs_eta = abs_calo_eta_i;
    s1_valid_d     = is_tower || is_hf;
  end

  ctere_ram #(
    .WIDTH(LUT_W),
    .DEPTH(EhDepth)
  ) u_ecal_table (
    .clk_i  (clk_i),
    .we_i   (wr_ecal && lut_et_ok),
    .waddr_i(eh_waddr),
    .wdata_i(lut_value_i),
    .re_i   (is_tower),
    .raddr_i(ecal_raddr),
    .rdata_o(ecal_word)
  );

  ctere_ram #(
    .WIDTH(LUT_W),
    .DEPTH(EhDepth)
  ) u_hcal_table (
    .clk_i  (clk_i),
    .we_i   (wr_hcal && lut_et_ok),
    .waddr_i(eh_waddr),
    .wdata_i(lut_value_i),
    .re_i   (is_tower),
    .raddr_i(hcal_raddr),
    .rdata_o(hcal_word)
  );

  ctere_ram #(
    .WIDTH(HF_W),
    .DEPTH(HfDepth)
  ) u_hf_table (
    .clk_i  (clk_i),
    .we_i   (wr_hf && lut_et_ok),
    .waddr_i(hf_waddr),
    .wdata_i(lut_value_i[HF_W-1:0]),
    .re_i   (is_hf),
    .raddr_i(hf_raddr),
    .rdata_o(hf_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_d) begin
      s1_item_q <= item_d;
    end
    if (s1_valid_q) begin
      res_q <= res_d;
    end
  end

  ctere_encode #(
    .ET_BITS(ET_BITS)
  ) u_encode (
    .item_i     (s1_item_q),
    .cfg_i      (cfg_q),
    .ecal_word_i(ecal_word),
    .hcal_word_i(hcal_word),
    .hf_word_i  (hf_word),
    .res_o      (res_d)
  );

  assign done_o            = done_q;
  assign tower_et_o        = res_q.tower_et;
  assign er_code_o         = res_q.er_code;
  assign zero_flag_o       = res_q.zero_flag;
  assign eohr_flag_o       = res_q.eohr_flag;
  assign hcal_flag_o       = res_q.hcal_flag;
  assign ecal_flag_o       = res_q.ecal_flag;
  assign ecal_calibrated_o = res_q.ecal_calibrated;
  assign hcal_calibrated_o = res_q.hcal_calibrated;

  // A tower or forward item always comes out after the table read and result registers.
  `CTERE_ASSERT_NXT(a_result_follows, s1_valid_d, ##1 done_o)
  // No result appears without an item in the table read stage before it.
  `CTERE_ASSERT_IMP(a_result_has_item, done_o, $past(s1_valid_q))
  // With both energies nonzero the sum and ratio code respect their limits.
  `CTERE_ASSERT_IMP(a_tower_limits, done_o && !zero_flag_o, (er_code_o <= cfg_q.er_limit) && (tower_et_o <= cfg_q.et_sum_limit))
  // A zero energy, and every forward tower, carries no ratio code.
  `CTERE_ASSERT_IMP(a_zero_no_ratio, done_o && zero_flag_o, er_code_o == '0)

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Testbench for calo_tower_et_ratio_encode: drives towers, forward towers and table loads.
// Checks every result against a predictor of its own. Depends on ctere_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import ctere_pkg::*;

  localparam int unsigned ET_SPAN = 1 << ET_BITS_DEF;
  localparam int unsigned EH_DEPTH = ETA_ROWS_DEF * 2 * ET_SPAN;
  localparam int unsigned HF_DEPTH = HF_ETA_ROWS_DEF * ET_SPAN;
  localparam int unsigned HF_HALF_FIRST = 30;
  localparam int unsigned HF_HALF_LAST = 39;
  localparam int unsigned HF_QUARTER_FIRST = 40;
  localparam int unsigned HF_QUARTER_LAST = 41;
  localparam int unsigned ABS_ETA_MAX = 41;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST = 3'd7;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTED = 30;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ETA_IN_W-1:0]  eta;
    logic [IN_ET_W-1:0]   e_et;
    logic                 e_fg;
    logic [IN_ET_W-1:0]   h_et;
    logic [FB_W-1:0]      h_fb;
    logic [ABS_ETA_W-1:0] abs_eta;
    logic                 lut_fb;
    logic [IN_ET_W-1:0]   lut_et;
    logic [LUT_W-1:0]     lut_value;
  } req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [OP_W-1:0]       op_i = '0;
  logic [ETA_IN_W-1:0]   eta_address_i = '0;
  logic [IN_ET_W-1:0]    ecal_et_i = '0;
  logic                  ecal_fg_i = 1'b0;
  logic [IN_ET_W-1:0]    hcal_et_i = '0;
  logic [FB_W-1:0]       hcal_fb_i = '0;
  logic [ABS_ETA_W-1:0]  abs_calo_eta_i = '0;
  logic                  lut_fb_i = 1'b0;
  logic [IN_ET_W-1:0]    lut_et_i = '0;
  logic [LUT_W-1:0]      lut_value_i = '0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  done_o;
  logic [SUM_W-1:0]      tower_et_o;
  logic [LOG_W-1:0]      er_code_o;
  logic                  zero_flag_o;
  logic                  eohr_flag_o;
  logic                  hcal_flag_o;
  logic                  ecal_flag_o;
  logic [IN_ET_W-1:0]    ecal_calibrated_o;
  logic [IN_ET_W-1:0]    hcal_calibrated_o;

  // Predictor copy of the registers and tables.
  logic             cfg_use_ecal = 1'b0;
  logic             cfg_use_hcal = 1'b0;
  logic             cfg_use_hf = 1'b0;
  logic [SUM_W-1:0] cfg_sum_limit = 9'd511;
  logic [LOG_W-1:0] cfg_er_limit = 3'd7;
  logic [LUT_W-1:0] ecal_lut [EH_DEPTH];
  logic [LUT_W-1:0] hcal_lut [EH_DEPTH];
  logic [HF_W-1:0]  hf_lut [HF_DEPTH];

  // Table words already loaded by queued items, so that no tower reads an unloaded word.
  bit ecal_loaded [EH_DEPTH];
  bit hcal_loaded [EH_DEPTH];
  bit hf_loaded [HF_DEPTH];

  req_t        tower_q [$];
  res_t        encoded_q [$];
  req_t        driven_item;
  int unsigned idle_pct = 0;
  int unsigned n_mismatch = 0;
  int unsigned quiet_cycles = 0;

  calo_tower_et_ratio_encode i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .eta_address_i    (eta_address_i),
    .ecal_et_i        (ecal_et_i),
    .ecal_fg_i        (ecal_fg_i),
    .hcal_et_i        (hcal_et_i),
    .hcal_fb_i        (hcal_fb_i),
    .abs_calo_eta_i   (abs_calo_eta_i),
    .lut_fb_i         (lut_fb_i),
    .lut_et_i         (lut_et_i),
    .lut_value_i      (lut_value_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .tower_et_o       (tower_et_o),
    .er_code_o        (er_code_o),
    .zero_flag_o      (zero_flag_o),
    .eohr_flag_o      (eohr_flag_o),
    .hcal_flag_o      (hcal_flag_o),
    .ecal_flag_o      (ecal_flag_o),
    .ecal_calibrated_o(ecal_calibrated_o),
    .hcal_calibrated_o(hcal_calibrated_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eh_addr(input logic [ETA_IN_W-1:0] eta, input logic fb,
                                          input logic [IN_ET_W-1:0] et);
    return ((int'(eta) % ETA_ROWS_DEF) * 2 + int'(fb)) * ET_SPAN + int'(et);
  endfunction

  function automatic int unsigned hf_addr(input logic [ETA_IN_W-1:0] eta,
                                          input logic [IN_ET_W-1:0] et);
    return (int'(eta) % HF_ETA_ROWS_DEF) * ET_SPAN + int'(et);
  endfunction

  // Calibrated energy of one side; the log code comes from the word or from the energy.
  function automatic int unsigned calibrate(input logic [IN_ET_W-1:0] et, input logic use_lut,
                                            input logic [LUT_W-1:0] word,
                                            output int unsigned log_code);
    int unsigned v;
    if (use_lut) begin
      log_code = word[LOG_LSB +: LOG_W];
      return word[IN_ET_W-1:0];
    end
    v = et;
    log_code = 0;
    while (v > 1) begin
      v = v >> 1;
      log_code++;
    end
    if (log_code > cfg_er_limit) log_code = cfg_er_limit;
    return et;
  endfunction

  // Applies one accepted item to the predictor; returns 1 when it gives a result.
  function automatic bit encode_item(input req_t it, output res_t r);
    int unsigned e_cal, h_cal, e_log, h_log, sum, ratio;
    r = '0;
    case (it.op)
      OP_WR_ECAL: begin
        ecal_lut[eh_addr(it.eta, it.lut_fb, it.lut_et)] = it.lut_value;
        return 1'b0;
      end
      OP_WR_HCAL: begin
        hcal_lut[eh_addr(it.eta, it.lut_fb, it.lut_et)] = it.lut_value;
        return 1'b0;
      end
      OP_WR_HF: begin
        hf_lut[hf_addr(it.eta, it.lut_et)] = it.lut_value[HF_W-1:0];
        return 1'b0;
      end
      OP_HF: begin
        h_cal = cfg_use_hf ? hf_lut[hf_addr(it.eta, it.h_et)] : it.h_et;
        if (it.abs_eta >= HF_HALF_FIRST && it.abs_eta <= HF_HALF_LAST) begin
          h_cal = h_cal / 2;
        end else if (it.abs_eta == HF_QUARTER_FIRST || it.abs_eta == HF_QUARTER_LAST) begin
          h_cal = h_cal / 4;
        end
        r.tower_et = SUM_W'(h_cal);
        r.zero_flag = 1'b1;
        r.hcal_flag = it.h_fb[1];
        r.ecal_flag = it.h_fb[0];
        return 1'b1;
      end
      OP_TOWER: begin
        e_cal = calibrate(it.e_et, cfg_use_ecal, ecal_lut[eh_addr(it.eta, it.e_fg, it.e_et)],
                          e_log);
        h_cal = calibrate(it.h_et, cfg_use_hcal,
                          hcal_lut[eh_addr(it.eta, it.h_fb[0], it.h_et)], h_log);
        sum = e_cal + h_cal;
        if (sum > cfg_sum_limit) sum = cfg_sum_limit;
        ratio = 0;
        if (e_cal == 0 || h_cal == 0) begin
          r.zero_flag = 1'b1;
          r.eohr_flag = (h_cal == 0 && e_cal != 0);
        end else if (e_cal == h_cal) begin
          r.eohr_flag = 1'b1;
        end else if (e_cal > h_cal) begin
          // A smaller log code on the larger energy saturates the ratio.
          ratio = (e_log >= h_log) ? e_log - h_log : cfg_er_limit;
          r.eohr_flag = 1'b1;
        end else begin
          ratio = (h_log >= e_log) ? h_log - e_log : cfg_er_limit;
        end
        if (ratio > cfg_er_limit) ratio = cfg_er_limit;
        r.tower_et = SUM_W'(sum);
        r.er_code = LOG_W'(ratio);
        r.hcal_flag = it.h_fb[0];
        r.ecal_flag = it.e_fg;
        r.ecal_calibrated = IN_ET_W'(e_cal);
        r.hcal_calibrated = IN_ET_W'(h_cal);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [IN_ET_W-1:0] rand_energy();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return IN_ET_W'($urandom_range(1, 7));
      default: return IN_ET_W'($urandom_range(0, ET_SPAN - 1));
    endcase
  endfunction

  function automatic logic [LUT_W-1:0] rand_word();
    return {LOG_W'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), rand_energy()};
  endfunction

  function automatic req_t mk_tower(input int unsigned eta, input int unsigned e_et,
                                    input bit e_fg, input int unsigned h_et,
                                    input int unsigned h_fb);
    req_t it;
    it = '0;
    it.op = OP_TOWER;
    it.eta = ETA_IN_W'(eta);
    it.e_et = IN_ET_W'(e_et);
    it.e_fg = e_fg;
    it.h_et = IN_ET_W'(h_et);
    it.h_fb = FB_W'(h_fb);
    return it;
  endfunction

  function automatic req_t mk_forward(input int unsigned eta, input int unsigned h_et,
                                      input int unsigned h_fb, input int unsigned abs_eta);
    req_t it;
    it = '0;
    it.op = OP_HF;
    it.eta = ETA_IN_W'(eta);
    it.h_et = IN_ET_W'(h_et);
    it.h_fb = FB_W'(h_fb);
    it.abs_eta = ABS_ETA_W'(abs_eta);
    return it;
  endfunction

  function automatic req_t mk_load(input logic [OP_W-1:0] op, input int unsigned eta,
                                   input bit fb, input int unsigned et,
                                   input logic [LUT_W-1:0] value);
    req_t it;
    it = '0;
    it.op = op;
    it.eta = ETA_IN_W'(eta);
    it.lut_fb = fb;
    it.lut_et = IN_ET_W'(et);
    it.lut_value = value;
    return it;
  endfunction

  function automatic req_t random_item();
    req_t it;
    int unsigned pick;
    it = '0;
    it.eta = ETA_IN_W'($urandom);
    // Half of the traffic stays on a few rows so that loads and reads meet.
    if ($urandom_range(0, 1) == 1) it.eta = ETA_IN_W'($urandom_range(0, 3));
    it.e_et = rand_energy();
    it.e_fg = 1'($urandom);
    it.h_et = rand_energy();
    it.h_fb = FB_W'($urandom);
    it.abs_eta = ABS_ETA_W'($urandom_range(0, ABS_ETA_MAX));
    it.lut_fb = 1'($urandom);
    it.lut_et = rand_energy();
    it.lut_value = rand_word();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.op = OP_TOWER;
      if ($urandom_range(0, 7) == 0) it.h_et = it.e_et;
    end else if (pick < 70) begin
      it.op = OP_HF;
    end else if (pick < 78) begin
      it.op = OP_WR_ECAL;
    end else if (pick < 86) begin
      it.op = OP_WR_HCAL;
    end else if (pick < 95) begin
      it.op = OP_WR_HF;
    end else begin
      it.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return it;
  endfunction

  // Queues an item; a read of an enabled table's word not yet loaded gets a load queued first.
  task automatic enqueue_item(input req_t it);
    case (it.op)
      OP_TOWER: begin
        if (cfg_use_ecal && !ecal_loaded[eh_addr(it.eta, it.e_fg, it.e_et)]) begin
          enqueue_item(mk_load(OP_WR_ECAL, it.eta, it.e_fg, it.e_et, rand_word()));
        end
        if (cfg_use_hcal && !hcal_loaded[eh_addr(it.eta, it.h_fb[0], it.h_et)]) begin
          enqueue_item(mk_load(OP_WR_HCAL, it.eta, it.h_fb[0], it.h_et, rand_word()));
        end
      end
      OP_HF: begin
        if (cfg_use_hf && !hf_loaded[hf_addr(it.eta, it.h_et)]) begin
          enqueue_item(mk_load(OP_WR_HF, it.eta, 1'b0, it.h_et, rand_word()));
        end
      end
      OP_WR_ECAL: ecal_loaded[eh_addr(it.eta, it.lut_fb, it.lut_et)] = 1'b1;
      OP_WR_HCAL: hcal_loaded[eh_addr(it.eta, it.lut_fb, it.lut_et)] = 1'b1;
      OP_WR_HF: hf_loaded[hf_addr(it.eta, it.lut_et)] = 1'b1;
      default: ;
    endcase
    tower_q.push_back(it);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_USE_ECAL_LUT: cfg_use_ecal = value[0];
      REG_USE_HCAL_LUT: cfg_use_hcal = value[0];
      REG_USE_HF_LUT: cfg_use_hf = value[0];
      REG_ET_SUM_LIMIT: cfg_sum_limit = value[SUM_W-1:0];
      REG_ER_LIMIT: cfg_er_limit = value[LOG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [2:0] lut_mode, input int unsigned sum_limit,
                              input int unsigned er_limit);
    write_reg(REG_USE_ECAL_LUT, CFG_DATA_W'(lut_mode[0]));
    write_reg(REG_USE_HCAL_LUT, CFG_DATA_W'(lut_mode[1]));
    write_reg(REG_USE_HF_LUT, CFG_DATA_W'(lut_mode[2]));
    write_reg(REG_ET_SUM_LIMIT, CFG_DATA_W'(sum_limit));
    write_reg(REG_ER_LIMIT, CFG_DATA_W'(er_limit));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Table loads give no result, so a further wait covers one still in the pipeline.
  task automatic wait_drain();
    do @(negedge clk_i);
    while (tower_q.size() != 0 || start_i || encoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic report(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : drive
    res_t enc;
    if (start_i && !busy_o) begin
      if (encode_item(driven_item, enc)) encoded_q.push_back(enc);
    end
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (tower_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        driven_item = tower_q.pop_front();
        start_i <= 1'b1;
        op_i <= driven_item.op;
        eta_address_i <= driven_item.eta;
        ecal_et_i <= driven_item.e_et;
        ecal_fg_i <= driven_item.e_fg;
        hcal_et_i <= driven_item.h_et;
        hcal_fb_i <= driven_item.h_fb;
        abs_calo_eta_i <= driven_item.abs_eta;
        lut_fb_i <= driven_item.lut_fb;
        lut_et_i <= driven_item.lut_et;
        lut_value_i <= driven_item.lut_value;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && done_o) begin
      if (encoded_q.size() == 0) begin
        report("result with no item waiting");
      end else begin
        want = encoded_q.pop_front();
        check_field("tower_et", tower_et_o, want.tower_et);
        check_field("er_code", er_code_o, want.er_code);
        check_field("zero_flag", zero_flag_o, want.zero_flag);
        check_field("eohr_flag", eohr_flag_o, want.eohr_flag);
        check_field("hcal_flag", hcal_flag_o, want.hcal_flag);
        check_field("ecal_flag", ecal_flag_o, want.ecal_flag);
        check_field("ecal_calibrated", ecal_calibrated_o, want.ecal_calibrated);
        check_field("hcal_calibrated", hcal_calibrated_o, want.hcal_calibrated);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  lut_modes [N_PHASES];
    int unsigned idle_modes [3];
    int unsigned n_items;
    int unsigned q_before;
    int unsigned sum_limit;
    int unsigned er_limit;
    req_t        it;
    lut_modes = '{3'b111, 3'b000, 3'b101, 3'b010, 3'b011, 3'b100, 3'b110, 3'b001};
    idle_modes = '{0, 52, 8};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: no tables, full limits.
    enqueue_item(mk_tower(0, 0, 1'b0, 0, 0));
    enqueue_item(mk_tower(1, 255, 1'b1, 0, 0));
    enqueue_item(mk_tower(2, 0, 1'b0, 255, 63));
    enqueue_item(mk_tower(31, 255, 1'b1, 255, 62));
    enqueue_item(mk_tower(3, 1, 1'b0, 255, 1));
    enqueue_item(mk_tower(4, 200, 1'b1, 3, 21));
    enqueue_item(mk_tower(5, 3, 1'b0, 200, 42));
    enqueue_item(mk_forward(31, 255, 1, 0));
    enqueue_item(mk_forward(16, 255, 2, 29));
    enqueue_item(mk_forward(7, 255, 3, 30));
    enqueue_item(mk_forward(0, 255, 63, 39));
    enqueue_item(mk_forward(9, 255, 0, 40));
    enqueue_item(mk_forward(15, 254, 2, 41));
    it = mk_tower(6, 17, 1'b1, 9, 1);
    it.op = OP_SPARE_FIRST;
    enqueue_item(it);
    it.op = OP_SPARE_FIRST + 3'd1;
    enqueue_item(it);
    it.op = OP_SPARE_LAST;
    enqueue_item(it);
    wait_drain();

    // All tables on, tight limits: negative log difference, large table log codes,
    // sum saturation and a forward row reached through an eta above the row count.
    program_regs(3'b111, 300, 2);
    enqueue_item(mk_load(OP_WR_ECAL, 5, 1'b0, 200, {3'd1, 4'h0, 8'd250}));
    enqueue_item(mk_load(OP_WR_HCAL, 5, 1'b1, 10, {3'd6, 4'h0, 8'd20}));
    enqueue_item(mk_tower(5, 200, 1'b0, 10, 1));
    enqueue_item(mk_load(OP_WR_ECAL, 6, 1'b1, 0, {3'd7, 4'h0, 8'd100}));
    enqueue_item(mk_load(OP_WR_HCAL, 6, 1'b0, 0, {3'd0, 4'h0, 8'd50}));
    enqueue_item(mk_tower(6, 0, 1'b1, 0, 0));
    enqueue_item(mk_load(OP_WR_ECAL, 7, 1'b0, 255, {3'd0, 4'hF, 8'd255}));
    enqueue_item(mk_load(OP_WR_HCAL, 7, 1'b0, 255, {3'd7, 4'hF, 8'd255}));
    enqueue_item(mk_tower(7, 255, 1'b0, 255, 62));
    enqueue_item(mk_load(OP_WR_HF, 20, 1'b1, 100, 15'h7FAB));
    enqueue_item(mk_forward(4, 100, 2, 41));
    wait_drain();

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p % 3)
        0: sum_limit = 511;
        1: sum_limit = 0;
        default: sum_limit = $urandom_range(1, 510);
      endcase
      case (p % 4)
        0: er_limit = 7;
        1: er_limit = 0;
        default: er_limit = $urandom_range(1, 6);
      endcase
      program_regs(lut_modes[p], sum_limit, er_limit);
      idle_pct = idle_modes[p % 3];
      n_items = 0;
      // Every queued item counts, the table loads that a read pulls in too.
      while (n_items < ITEMS_PER_PHASE) begin
        it = random_item();
        q_before = tower_q.size();
        enqueue_item(it);
        n_items += tower_q.size() - q_before;
      end
      wait_drain();
    end

    if (n_mismatch == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ctere_pkg.sv
design/ctere_ram.sv
design/ctere_encode.sv
design/calo_tower_et_ratio_encode.sv
sim/tb.sv
